// ----- hdl/jhs_pkg.sv -----
// ----------------------------------------------------------------------------
// JPEG header size scanner package
// Marker codes and the result record shared by the scanner modules.
// ----------------------------------------------------------------------------
package jhs_pkg;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_SOF0   = 8'hC0;
  localparam logic [7:0] MARK_SOF1   = 8'hC1;
  localparam logic [7:0] MARK_SOF2   = 8'hC2;

  // Offsets inside a frame header, counted from the first length byte.
  localparam logic [2:0] SOF_HEIGHT_HI = 3'd3;
  localparam logic [2:0] SOF_HEIGHT_LO = 3'd4;
  localparam logic [2:0] SOF_WIDTH_HI  = 3'd5;
  localparam logic [2:0] SOF_WIDTH_LO  = 3'd6;
  localparam logic [2:0] SOF_LAST      = 3'd7;

  typedef struct packed {
    logic        found;
    logic [15:0] width;
    logic [15:0] height;
  } res_t;

endpackage

// ----- hdl/jhs_core.sv -----
// ----------------------------------------------------------------------------
// JPEG header size scanner core
// Marker state machine that advances by one byte per step and reports the
// frame size on the step that carries the final byte of a buffer.
// ----------------------------------------------------------------------------
module jhs_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output jhs_pkg::res_t result
);

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_MARK,
    PH_LEN,
    PH_SKIP,
    PH_SOF,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  offset, offset_next;
  logic [15:0] seg_len, seg_len_next;
  logic [15:0] height, height_next;
  logic [15:0] width, width_next;
  logic        found, found_next;
  logic [15:0] len_full;

  always_comb begin
    phase_next   = phase;
    offset_next  = offset;
    seg_len_next = seg_len;
    height_next  = height;
    width_next   = width;
    found_next   = found;
    len_full     = {seg_len[15:8], data_byte};
    unique case (phase)
      PH_SEEK: begin
        if (data_byte == jhs_pkg::MARK_PREFIX) begin
          phase_next = PH_MARK;
        end
      end
      PH_MARK: begin
        if (data_byte == jhs_pkg::MARK_SOI) begin
          phase_next = PH_SEEK;
        end else if (data_byte == jhs_pkg::MARK_EOI) begin
          phase_next = PH_DONE;
        end else if (data_byte == jhs_pkg::MARK_PREFIX) begin
          phase_next = PH_MARK;
        end else if (data_byte == jhs_pkg::MARK_SOF0 || data_byte == jhs_pkg::MARK_SOF1 ||
                     data_byte == jhs_pkg::MARK_SOF2) begin
          phase_next  = PH_SOF;
          offset_next = '0;
        end else begin
          phase_next  = PH_LEN;
          offset_next = '0;
        end
      end
      PH_LEN: begin
        if (offset[0] == 1'b0) begin
          seg_len_next = {data_byte, 8'h00};
          offset_next  = 3'd1;
        end else begin
          seg_len_next = (len_full >= 16'd2) ? (len_full - 16'd2) : 16'd0;
          offset_next  = '0;
          phase_next   = (seg_len_next == 16'd0) ? PH_SEEK : PH_SKIP;
        end
      end
      PH_SKIP: begin
        seg_len_next = seg_len - 16'd1;
        if (seg_len_next == 16'd0) begin
          phase_next = PH_SEEK;
        end
      end
      PH_SOF: begin
        case (offset)
          jhs_pkg::SOF_HEIGHT_HI: height_next = {data_byte, 8'h00};
          jhs_pkg::SOF_HEIGHT_LO: height_next = {height[15:8], data_byte};
          jhs_pkg::SOF_WIDTH_HI:  width_next  = {data_byte, 8'h00};
          jhs_pkg::SOF_WIDTH_LO:  width_next  = {width[15:8], data_byte};
          default: ;
        endcase
        if (offset == jhs_pkg::SOF_LAST) begin
          found_next  = 1'b1;
          phase_next  = PH_DONE;
          offset_next = '0;
        end else begin
          offset_next = offset + 3'd1;
        end
      end
      PH_DONE: ;
      default: phase_next = PH_SEEK;
    endcase
  end

  always_comb begin
    result.found  = found_next;
    result.width  = found_next ? width_next : 16'd0;
    result.height = found_next ? height_next : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      phase   <= PH_SEEK;
      offset  <= '0;
      seg_len <= '0;
      height  <= '0;
      width   <= '0;
      found   <= 1'b0;
    end else if (step) begin
      phase   <= phase_next;
      offset  <= offset_next;
      seg_len <= seg_len_next;
      height  <= height_next;
      width   <= width_next;
      found   <= found_next;
    end
  end

endmodule

// ----- hdl/jpeg_header_size_scanner.sv -----
// A final byte passes through the input register, then the result register.
// Throughput: one byte per cycle; the marker state machine in the core takes
// one byte in each cycle, and only a final byte waits on a stalled result.
// Reset (rst, synchronous) empties the input and result registers and returns
// the scanner to searching for a marker prefix.
// ----------------------------------------------------------------------------
// JPEG header size scanner
// Scans a JPEG byte stream for a frame header and reports width and height
// once per buffer, on the byte marked as the last one.
// ----------------------------------------------------------------------------
module jpeg_header_size_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        size_found,
  output logic [15:0] image_width,
  output logic [15:0] image_height
);

  logic          in_q_valid;
  logic [7:0]    in_q_byte;
  logic          in_q_last;
  logic          advance;
  logic          accept_in;
  jhs_pkg::res_t core_res;
  jhs_pkg::res_t res_q;
  logic          res_valid;

  assign advance   = in_q_valid && (!in_q_last || !res_valid || !out_stall);
  assign in_stall  = in_q_valid && !advance;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept_in) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
    if (accept_in) begin
      in_q_byte <= data_byte;
      in_q_last <= last_byte;
    end
  end

  jhs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_q_byte),
    .last_byte (in_q_last),
    .result    (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && in_q_last) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
    if (advance && in_q_last) begin
      res_q <= core_res;
    end
  end

  assign out_valid    = res_valid;
  assign size_found   = res_q.found;
  assign image_width  = res_q.width;
  assign image_height = res_q.height;

endmodule

// ----- hdl/jhs_checker.sv -----
// ----------------------------------------------------------------------------
// JPEG header size scanner checker
// Port-level checks on the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
module jhs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic        size_found,
  input logic [15:0] image_width,
  input logic [15:0] image_height
);

  // A result that has not been taken stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn before its transfer");

  // Without a frame header the reported size is zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !size_found |-> image_width == 16'd0 && image_height == 16'd0)
    else $error("nonzero size reported without a frame header");

  // The input only waits behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result side was free");

  // A fresh result follows the transfer of a final byte.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && last_byte, 2))
    else $error("result without a final byte");

  // Reset empties the result register.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind jpeg_header_size_scanner jhs_checker u_jhs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .last_byte    (last_byte),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .size_found   (size_found),
  .image_width  (image_width),
  .image_height (image_height)
);

// ----- tb/sv/jpeg_header_size_scanner_chk.sv -----
// ----------------------------------------------------------------------------
// JPEG header size scanner checker
// Watches both channels of the scanner and tracks the marker search on every
// accepted byte. It queues the frame size expected for each final byte and
// compares every result transfer with the oldest queued entry, field by field.
// ----------------------------------------------------------------------------
module jpeg_header_size_scanner_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        size_found,
  input  logic [15:0] image_width,
  input  logic [15:0] image_height,
  output int          mismatches,
  output int          results_waiting
);

  typedef enum logic [2:0] {
    ST_SEEK,
    ST_MARKER,
    ST_LEN,
    ST_SKIP,
    ST_FRAME,
    ST_DONE
  } scan_state_t;

  scan_state_t   state;
  logic [2:0]    seg_pos;
  logic [15:0]   skip_left;
  logic [15:0]   height_q;
  logic [15:0]   width_q;
  logic          found_q;
  jhs_pkg::res_t size_q[$];
  jhs_pkg::res_t want;

  initial begin
    mismatches = 0;
    results_waiting = 0;
  end

  task automatic report(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_scan();
    state = ST_SEEK;
    seg_pos = '0;
    skip_left = '0;
    height_q = '0;
    width_q = '0;
    found_q = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic lst);
    logic [15:0]   seg_len;
    jhs_pkg::res_t res;
    case (state)
      ST_SEEK: begin
        if (b == jhs_pkg::MARK_PREFIX) state = ST_MARKER;
      end
      ST_MARKER: begin
        if (b == jhs_pkg::MARK_SOI) begin
          state = ST_SEEK;
        end else if (b == jhs_pkg::MARK_EOI) begin
          state = ST_DONE;
        end else if (b == jhs_pkg::MARK_PREFIX) begin
          state = ST_MARKER;
        end else if (b == jhs_pkg::MARK_SOF0 || b == jhs_pkg::MARK_SOF1 ||
                     b == jhs_pkg::MARK_SOF2) begin
          state = ST_FRAME;
          seg_pos = '0;
        end else begin
          state = ST_LEN;
          seg_pos = '0;
        end
      end
      ST_LEN: begin
        if (seg_pos == 3'd0) begin
          skip_left = {b, 8'h00};
          seg_pos = 3'd1;
        end else begin
          // Lengths below two behave as an empty segment.
          seg_len = skip_left | {8'h00, b};
          skip_left = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
          seg_pos = '0;
          state = (skip_left == 16'd0) ? ST_SEEK : ST_SKIP;
        end
      end
      ST_SKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) state = ST_SEEK;
      end
      ST_FRAME: begin
        case (seg_pos)
          jhs_pkg::SOF_HEIGHT_HI: height_q = {b, 8'h00};
          jhs_pkg::SOF_HEIGHT_LO: height_q = height_q | {8'h00, b};
          jhs_pkg::SOF_WIDTH_HI:  width_q = {b, 8'h00};
          jhs_pkg::SOF_WIDTH_LO:  width_q = width_q | {8'h00, b};
          default: ;
        endcase
        if (seg_pos >= jhs_pkg::SOF_LAST) begin
          found_q = 1'b1;
          state = ST_DONE;
          seg_pos = '0;
        end else begin
          seg_pos = seg_pos + 3'd1;
        end
      end
      default: ;
    endcase
    if (lst) begin
      res.found = found_q;
      res.width = found_q ? width_q : 16'd0;
      res.height = found_q ? height_q : 16'd0;
      size_q.push_back(res);
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      size_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (size_q.size() == 0) begin
          report("result transfer with no frame size pending");
        end else begin
          want = size_q.pop_front();
          if (size_found !== want.found)
            report($sformatf("size_found %b, expected %b", size_found, want.found));
          if (image_width !== want.width)
            report($sformatf("image_width %0d, expected %0d", image_width, want.width));
          if (image_height !== want.height)
            report($sformatf("image_height %0d, expected %0d", image_height, want.height));
        end
      end
      if (in_valid && !in_stall) scan_byte(data_byte, last_byte);
    end
    results_waiting = size_q.size();
  end

endmodule

// ----- tb/sv/jpeg_header_size_scanner_tb.sv -----
// ----------------------------------------------------------------------------
// JPEG header size scanner testbench
// Sends short directed buffers and then random buffers, mostly well-formed
// JPEG headers with random segments, fill, truncation and noise, through the
// scanner with random gaps and stalls. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module jpeg_header_size_scanner_tb;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic        size_found;
  logic [15:0] image_width;
  logic [15:0] image_height;
  int          mismatches;
  int          results_waiting;

  logic [7:0]  frame_bytes[$];
  logic        hold_off;
  logic        no_idle;
  int          bytes_sent;

  jpeg_header_size_scanner dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .size_found   (size_found),
    .image_width  (image_width),
    .image_height (image_height)
  );

  jpeg_header_size_scanner_chk chk (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .size_found      (size_found),
    .image_width     (image_width),
    .image_height    (image_height),
    .mismatches      (mismatches),
    .results_waiting (results_waiting)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // The receiver stalls in random runs, or holds off for a long stretch
  // once when the stimulus asks for it.
  initial begin
    int n;
    bit hold_done;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off && !hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_done = 1'b1;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        n = idle_cycles();
        if (n == 0) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(0, 6)) @(negedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int n;
    @(negedge clk);
    n = no_idle ? 0 : idle_cycles();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame_bytes();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  function automatic logic [15:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'h0000;
    if (r < 30) return 16'hFFFF;
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic logic [7:0] pick_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return jhs_pkg::MARK_PREFIX;
    if (r < 36) return jhs_pkg::MARK_SOI;
    if (r < 42) return jhs_pkg::MARK_EOI;
    if (r < 48) return 8'(jhs_pkg::MARK_SOF0 + $urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_segment();
    logic [7:0]  m;
    logic [15:0] seg_len;
    int          n;
    int          r;
    m = 8'($urandom_range(0, 255));
    while (m == jhs_pkg::MARK_PREFIX || m == jhs_pkg::MARK_SOI || m == jhs_pkg::MARK_EOI ||
           m == jhs_pkg::MARK_SOF0 || m == jhs_pkg::MARK_SOF1 || m == jhs_pkg::MARK_SOF2)
      m = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 80) begin
      n = $urandom_range(0, 10);
      seg_len = 16'(n + 2);
    end else if (r < 90) begin
      n = $urandom_range(0, 3);
      seg_len = 16'($urandom_range(0, 1));
    end else begin
      n = $urandom_range(0, 6);
      seg_len = 16'($urandom_range(0, 65535));
    end
    frame_bytes.push_back(jhs_pkg::MARK_PREFIX);
    frame_bytes.push_back(m);
    frame_bytes.push_back(seg_len[15:8]);
    frame_bytes.push_back(seg_len[7:0]);
    repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_frame_header();
    logic [15:0] h;
    logic [15:0] w;
    h = pick_dim();
    w = pick_dim();
    frame_bytes.push_back(jhs_pkg::MARK_PREFIX);
    frame_bytes.push_back(8'(jhs_pkg::MARK_SOF0 + $urandom_range(0, 2)));
    frame_bytes.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h00);
    frame_bytes.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : 8'h11);
    frame_bytes.push_back(8'h08);
    frame_bytes.push_back(h[15:8]);
    frame_bytes.push_back(h[7:0]);
    frame_bytes.push_back(w[15:8]);
    frame_bytes.push_back(w[7:0]);
    repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_header_buffer();
    int k;
    frame_bytes.delete();
    if ($urandom_range(0, 9) != 0) begin
      frame_bytes.push_back(jhs_pkg::MARK_PREFIX);
      frame_bytes.push_back(jhs_pkg::MARK_SOI);
    end
    repeat ($urandom_range(0, 3)) add_segment();
    if ($urandom_range(0, 9) == 0) begin
      frame_bytes.push_back(jhs_pkg::MARK_PREFIX);
      frame_bytes.push_back(jhs_pkg::MARK_EOI);
    end
    repeat ($urandom_range(0, 2)) frame_bytes.push_back(jhs_pkg::MARK_PREFIX);
    add_frame_header();
    if ($urandom_range(0, 3) == 0) begin
      frame_bytes.push_back(jhs_pkg::MARK_PREFIX);
      frame_bytes.push_back(jhs_pkg::MARK_EOI);
    end
    repeat ($urandom_range(0, 3)) frame_bytes.push_back(pick_noise());
    if ($urandom_range(0, 4) == 0) begin
      k = $urandom_range(1, frame_bytes.size());
      while (frame_bytes.size() > k) void'(frame_bytes.pop_back());
    end
  endtask

  task automatic build_noise_buffer(input int max_len);
    frame_bytes.delete();
    repeat ($urandom_range(1, max_len)) frame_bytes.push_back(pick_noise());
  endtask

  initial begin
    bit held;
    bit paused;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    hold_off = 1'b0;
    no_idle = 1'b0;
    bytes_sent = 0;
    held = 1'b0;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Complete frame header with the largest dimensions.
    frame_bytes = {jhs_pkg::MARK_PREFIX, jhs_pkg::MARK_SOF0, 8'h00, 8'h11, 8'h08,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01};
    send_frame_bytes();
    frame_bytes = {jhs_pkg::MARK_PREFIX, jhs_pkg::MARK_EOI};
    send_frame_bytes();
    // A short length resumes the search right after the length field.
    frame_bytes = {jhs_pkg::MARK_PREFIX, 8'hE0, 8'h00, 8'h01, jhs_pkg::MARK_PREFIX};
    send_frame_bytes();
    frame_bytes = {jhs_pkg::MARK_PREFIX, jhs_pkg::MARK_PREFIX, jhs_pkg::MARK_SOI, 8'h7F};
    send_frame_bytes();
    frame_bytes = {jhs_pkg::MARK_PREFIX, jhs_pkg::MARK_SOF2, 8'h00};
    send_frame_bytes();
    frame_bytes = {8'h00};
    send_frame_bytes();

    while (bytes_sent < 600) begin
      if (!held && bytes_sent > 200) begin
        held = 1'b1;
        hold_off = 1'b1;
        no_idle = 1'b1;
        repeat (8) begin
          build_noise_buffer(3);
          send_frame_bytes();
        end
        no_idle = 1'b0;
      end
      if (!paused && bytes_sent > 400) begin
        paused = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_waiting != 0) @(negedge clk);
      end
      no_idle = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 4) == 0) build_noise_buffer(12);
      else build_header_buffer();
      send_frame_bytes();
    end
    no_idle = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (results_waiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && results_waiting == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/jhs_pkg.sv
hdl/jhs_core.sv
hdl/jpeg_header_size_scanner.sv
hdl/jhs_checker.sv
tb/sv/jpeg_header_size_scanner_chk.sv
tb/sv/jpeg_header_size_scanner_tb.sv
